// ===== rtl/ugim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 glyph mapper package
// Byte classes, accent codes, glyph constants and the decode and glyph
// lookup functions used by the UTF-8 to glyph index mapper.
// ----------------------------------------------------------------------------
package ugim_pkg;

  // UTF-8 byte classes.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // Accent kinds.
  localparam logic [2:0] ACC_NONE   = 3'd0;
  localparam logic [2:0] ACC_ACUTE  = 3'd1;
  localparam logic [2:0] ACC_DOT    = 3'd2;
  localparam logic [2:0] ACC_OGONEK = 3'd3;
  localparam logic [2:0] ACC_STROKE = 3'd4;
  localparam logic [2:0] ACC_UMLAUT = 3'd5;
  localparam logic [2:0] ACC_TILDE  = 3'd6;

  // Cyrillic ranges and their Windows-1251 bases.
  localparam logic [15:0] CYR_UPPER_FIRST = 16'h0410;
  localparam logic [15:0] CYR_UPPER_LAST  = 16'h042F;
  localparam logic [7:0]  CYR_UPPER_BASE  = 8'hC0;
  localparam logic [15:0] CYR_LOWER_FIRST = 16'h0430;
  localparam logic [15:0] CYR_LOWER_LAST  = 16'h044F;
  localparam logic [7:0]  CYR_LOWER_BASE  = 8'hE0;
  localparam logic [7:0]  GLYPH_IO_UPPER  = 8'hA8;
  localparam logic [7:0]  GLYPH_IO_LOWER  = 8'hB8;
  localparam logic [7:0]  GLYPH_UNKNOWN   = 8'h3F;

  // Window of up to three bytes waiting to be decoded.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n;
  } win_t;

  // Result of one decode step on the front of a window.
  typedef struct packed {
    win_t        rest;
    logic        fire;
    logic [15:0] cp;
  } step_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [2:0] accent;
  } glyph_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_CODE;
  endfunction

  // Decodes one character at the front of the window. A zero byte count
  // means the sequence is incomplete and must wait for more bytes.
  function automatic step_t decode_step(input win_t w, input logic ending);
    step_t      s;
    logic [1:0] used;
    used   = 2'd1;
    s.cp   = {8'h00, w.b0};
    if (w.b0[7] == 1'b0) begin
      used = 2'd1;
    end else if ((w.b0 & LEAD2_MASK) == LEAD2_CODE) begin
      if (w.n < 2'd2) begin
        used = ending ? 2'd1 : 2'd0;
      end else if (is_cont(w.b1)) begin
        s.cp = {5'd0, w.b0[4:0], w.b1[5:0]};
        used = 2'd2;
      end
    end else if ((w.b0 & LEAD3_MASK) == LEAD3_CODE) begin
      if (w.n < 2'd2) begin
        used = ending ? 2'd1 : 2'd0;
      end else if (!is_cont(w.b1)) begin
        used = 2'd1;
      end else if (w.n < 2'd3) begin
        used = ending ? 2'd1 : 2'd0;
      end else if (is_cont(w.b2)) begin
        s.cp = {w.b0[3:0], w.b1[5:0], w.b2[5:0]};
        used = 2'd3;
      end
    end
    s.fire = (w.n != 2'd0) && (used != 2'd0);
    s.rest = w;
    if (s.fire) begin
      s.rest.n = w.n - used;
      unique case (used)
        2'd1: begin
          s.rest.b0 = w.b1;
          s.rest.b1 = w.b2;
          s.rest.b2 = 8'h00;
        end
        2'd2: begin
          s.rest.b0 = w.b2;
          s.rest.b1 = 8'h00;
          s.rest.b2 = 8'h00;
        end
        default: begin
          s.rest.b0 = 8'h00;
          s.rest.b1 = 8'h00;
          s.rest.b2 = 8'h00;
        end
      endcase
    end
    return s;
  endfunction

  // Maps a code point to a legacy glyph index and an accent kind.
  function automatic glyph_t map_glyph(input logic [15:0] cp);
    glyph_t      g;
    logic [15:0] off;
    g.glyph  = GLYPH_UNKNOWN;
    g.accent = ACC_NONE;
    off      = 16'h0000;
    unique case (cp)
      16'h0104: begin g.glyph = "A"; g.accent = ACC_OGONEK; end
      16'h0105: begin g.glyph = "a"; g.accent = ACC_OGONEK; end
      16'h0106: begin g.glyph = "C"; g.accent = ACC_ACUTE;  end
      16'h0107: begin g.glyph = "c"; g.accent = ACC_ACUTE;  end
      16'h0118: begin g.glyph = "E"; g.accent = ACC_OGONEK; end
      16'h0119: begin g.glyph = "e"; g.accent = ACC_OGONEK; end
      16'h0141: begin g.glyph = "L"; g.accent = ACC_STROKE; end
      16'h0142: begin g.glyph = "l"; g.accent = ACC_STROKE; end
      16'h0143: begin g.glyph = "N"; g.accent = ACC_ACUTE;  end
      16'h0144: begin g.glyph = "n"; g.accent = ACC_ACUTE;  end
      16'h00D3: begin g.glyph = "O"; g.accent = ACC_ACUTE;  end
      16'h00F3: begin g.glyph = "o"; g.accent = ACC_ACUTE;  end
      16'h015A: begin g.glyph = "S"; g.accent = ACC_ACUTE;  end
      16'h015B: begin g.glyph = "s"; g.accent = ACC_ACUTE;  end
      16'h0179: begin g.glyph = "Z"; g.accent = ACC_ACUTE;  end
      16'h017A: begin g.glyph = "z"; g.accent = ACC_ACUTE;  end
      16'h017B: begin g.glyph = "Z"; g.accent = ACC_DOT;    end
      16'h017C: begin g.glyph = "z"; g.accent = ACC_DOT;    end
      16'h00C4: begin g.glyph = "A"; g.accent = ACC_UMLAUT; end
      16'h00E4: begin g.glyph = "a"; g.accent = ACC_UMLAUT; end
      16'h00D6: begin g.glyph = "O"; g.accent = ACC_UMLAUT; end
      16'h00F6: begin g.glyph = "o"; g.accent = ACC_UMLAUT; end
      16'h00DC: begin g.glyph = "U"; g.accent = ACC_UMLAUT; end
      16'h00FC: begin g.glyph = "u"; g.accent = ACC_UMLAUT; end
      16'h00C1: begin g.glyph = "A"; g.accent = ACC_ACUTE;  end
      16'h00E1: begin g.glyph = "a"; g.accent = ACC_ACUTE;  end
      16'h00C9: begin g.glyph = "E"; g.accent = ACC_ACUTE;  end
      16'h00E9: begin g.glyph = "e"; g.accent = ACC_ACUTE;  end
      16'h00CD: begin g.glyph = "I"; g.accent = ACC_ACUTE;  end
      16'h00ED: begin g.glyph = "i"; g.accent = ACC_ACUTE;  end
      16'h00DA: begin g.glyph = "U"; g.accent = ACC_ACUTE;  end
      16'h00FA: begin g.glyph = "u"; g.accent = ACC_ACUTE;  end
      16'h00D1: begin g.glyph = "N"; g.accent = ACC_TILDE;  end
      16'h00F1: begin g.glyph = "n"; g.accent = ACC_TILDE;  end
      16'h00BF: g.glyph = "?";
      16'h00A1: g.glyph = "!";
      16'h0401: g.glyph = GLYPH_IO_UPPER;
      16'h0451: g.glyph = GLYPH_IO_LOWER;
      default: begin
        if (cp >= CYR_UPPER_FIRST && cp <= CYR_UPPER_LAST) begin
          off     = cp - CYR_UPPER_FIRST;
          g.glyph = CYR_UPPER_BASE + {3'd0, off[4:0]};
        end else if (cp >= CYR_LOWER_FIRST && cp <= CYR_LOWER_LAST) begin
          off     = cp - CYR_LOWER_FIRST;
          g.glyph = CYR_LOWER_BASE + {3'd0, off[4:0]};
        end else if (cp[15:8] == 8'h00) begin
          g.glyph = cp[7:0];
        end
      end
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/utf8_to_glyph_index_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to glyph index mapper
// Decodes one- to three-byte UTF-8 from a byte stream, passes bad leads
// through raw, and maps each character to a legacy glyph index and accent.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/stall    text_byte[7:0], final_byte
// out_      output     out_valid/stall   code_point[15:0], glyph_index[7:0],
//                                        accent_kind[2:0], last_of_run, text_end
//
// An item passes through the input register, the decode buffer and the output
// register, in that order.
// An item that yields several results shows them one at a time on the single
// output port; items with one result flow at one per cycle while out_stall is low.
// Reset (synchronous, rst_n low) empties all stages and the pending bytes.
// A stall on the output backs up through the buffer into in_stall.
module utf8_to_glyph_index_mapper
  import ugim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_point,
  output logic [7:0]       out_glyph_index,
  output logic [2:0]       out_accent_kind,
  output logic             out_last_of_run,
  output logic             out_text_end
);

  // Input register.
  logic        a_valid_r;
  logic [7:0]  a_byte_r;
  logic        a_final_r;

  // Decode buffer: up to three code points of one item, front at index 0.
  logic [15:0] b_cp_r [3];
  logic [1:0]  b_cnt_r;
  logic        b_end_r;

  // Pending bytes of an unfinished sequence.
  logic [7:0]  held0_r;
  logic [7:0]  held1_r;
  logic [1:0]  held_cnt_r;
  logic [7:0]  held0_nxt;
  logic [7:0]  held1_nxt;
  logic [1:0]  held_cnt_nxt;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_cp_r;
  logic [7:0]  out_glyph_r;
  logic [2:0]  out_accent_r;
  logic        out_last_r;
  logic        out_end_r;

  logic        has_byte;
  logic        ending;
  win_t        win;
  step_t       s1;
  step_t       s2;
  step_t       s3;
  logic [1:0]  dec_cnt;
  glyph_t      front_glyph;

  logic        c_free;
  logic        pop;
  logic        b_free;
  logic        a_fire;
  logic        in_fire;

  // Handshake between the stages.
  assign c_free   = !out_valid_r || !out_stall;
  assign pop      = (b_cnt_r != 2'd0) && c_free;
  assign b_free   = (b_cnt_r == 2'd0) || ((b_cnt_r == 2'd1) && pop);
  assign a_fire   = a_valid_r && b_free;
  assign in_stall = a_valid_r && !b_free;
  assign in_fire  = in_valid && !in_stall;

  // Build the byte window from the pending bytes and the new byte.
  always_comb begin
    has_byte = (a_byte_r != 8'h00);
    ending   = !has_byte || a_final_r;
    win      = '0;
    unique case (held_cnt_r)
      2'd0: begin
        win.b0 = a_byte_r;
        win.n  = {1'b0, has_byte};
      end
      2'd1: begin
        win.b0 = held0_r;
        win.b1 = a_byte_r;
        win.n  = 2'd1 + {1'b0, has_byte};
      end
      default: begin
        win.b0 = held0_r;
        win.b1 = held1_r;
        win.b2 = a_byte_r;
        win.n  = 2'd2 + {1'b0, has_byte};
      end
    endcase
  end

  // Three chained decode steps; a step that does not fire leaves the window.
  assign s1      = decode_step(win, ending);
  assign s2      = decode_step(s1.rest, ending);
  assign s3      = decode_step(s2.rest, ending);
  assign dec_cnt = {1'b0, s1.fire} + {1'b0, s2.fire} + {1'b0, s3.fire};

  // Pending bytes after this item; an ending item flushes everything.
  always_comb begin
    if (ending || s3.rest.n == 2'd3) begin
      held_cnt_nxt = 2'd0;
    end else begin
      held_cnt_nxt = s3.rest.n;
    end
    held0_nxt = (held_cnt_nxt != 2'd0) ? s3.rest.b0 : 8'h00;
    held1_nxt = (held_cnt_nxt == 2'd2) ? s3.rest.b1 : 8'h00;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
    if (in_fire) begin
      a_byte_r  <= in_text_byte;
      a_final_r <= in_final_byte;
    end
  end

  // Pending byte state advances once per decoded item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r    <= 8'h00;
      held1_r    <= 8'h00;
      held_cnt_r <= 2'd0;
    end else if (a_fire) begin
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

  // Decode buffer: load a whole item or shift out the front entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cnt_r <= 2'd0;
    end else if (a_fire) begin
      b_cnt_r <= dec_cnt;
    end else if (pop) begin
      b_cnt_r <= b_cnt_r - 2'd1;
    end
    if (a_fire) begin
      b_cp_r[0] <= s1.cp;
      b_cp_r[1] <= s2.cp;
      b_cp_r[2] <= s3.cp;
      b_end_r   <= ending;
    end else if (pop) begin
      b_cp_r[0] <= b_cp_r[1];
      b_cp_r[1] <= b_cp_r[2];
    end
  end

  assign front_glyph = map_glyph(b_cp_r[0]);

  // Output register with glyph lookup on the way in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_cp_r     <= b_cp_r[0];
      out_glyph_r  <= front_glyph.glyph;
      out_accent_r <= front_glyph.accent;
      out_last_r   <= (b_cnt_r == 2'd1);
      out_end_r    <= (b_cnt_r == 2'd1) && b_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = out_cp_r;
  assign out_glyph_index = out_glyph_r;
  assign out_accent_kind = out_accent_r;
  assign out_last_of_run = out_last_r;
  assign out_text_end    = out_end_r;

  // A result that is not the last of its item has its successors buffered.
  a_rest_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (b_cnt_r != 2'd0))
    else $error("non-last result shown with an empty decode buffer");

  // The end-of-text mark only rides on the last result of an item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_last_r)
    else $error("text end flagged on a result that is not last of its item");

  // An ending item leaves nothing pending.
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && ending) |=> (held_cnt_r == 2'd0))
    else $error("pending bytes remain after an ending item");

  // Never more than two pending bytes.
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd3)
    else $error("pending byte count out of range");

endmodule
`default_nettype wire
